// File: src/lpdm_pkg.sv
// Shared types and constants of the logical page to device mapper.
// No dependencies; used by every module of the block.
`default_nettype none
package lpdm_pkg;

    localparam int CNT_W   = 9;   // device counts up to 256
    localparam int FIRST_W = 42;  // running first extent of the raw scan, signed

    localparam logic [2:0] CFG_KIND  = 3'd0;
    localparam logic [2:0] CFG_ESZ   = 3'd1;
    localparam logic [2:0] CFG_TOTAL = 3'd2;
    localparam logic [2:0] CFG_NDEV  = 3'd3;
    localparam logic [2:0] CFG_RESV  = 3'd4;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_RAW  = 2'd1;

    localparam logic ACT_XLATE = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_BADKIND = 2'd2;

    typedef struct packed {
        logic               action;
        logic signed [31:0] page_number;
        logic [3:0]         entry_index;
        logic [30:0]        entry_first_extent;
        logic [30:0]        entry_extent_count;
    } t_in;

    typedef struct packed {
        logic [3:0]  device_number;
        logic [30:0] offset_in_device;
        logic [1:0]  status;
    } t_out;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_XLATE,
        OP_BADKIND,
        OP_NEG
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [30:0] page;
        logic [3:0]  index;
        logic [30:0] first_extent;
        logic [30:0] extent_count;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       kind;
        logic [15:0]      esz;    // never zero
        logic [30:0]      total;
        logic [CNT_W-1:0] ndev;   // clamped to 1..MAX_DEVICES
        logic [7:0]       resv;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIM_MUL,
        S_LIM_CHK,
        S_DIV,
        S_BS_RD,
        S_BS_CMP,
        S_RS_RD,
        S_RS_CMP,
        S_OFF_RD,
        S_OFF_LD,
        S_OFF_MUL,
        S_OFF_SUB,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// File: src/logical_page_to_device_mapper_core.sv
// Top level of the logical page to device mapper: configuration registers,
// front end queue and back end. Depends on lpdm_pkg, lpdm_front, lpdm_back.
`default_nettype none
// Translates a logical page of a volume concatenated over up to MAX_DEVICES
// devices into a device number and a page offset. Items enter through a
// queue-style port (push/full); a write item loads one device table entry
// and gives no result, a translate item gives one result on the pop/empty
// port. A two-entry queue parts the front end from the back end, and the
// result register lets the next item start while a result waits.
// Sequence: a write is done in the back end's idle state. A translate runs,
// from the state where the back end takes it to the load of the result
// register, through a range check, a restoring divider by extent size and
// a table walk over the table memory, with a read and a compare state per
// probe (data volumes: at most log2(devices)+1 probes, plus S_OFF_RD and
// S_OFF_LD when no entry matches exactly; raw volumes: at most one probe
// per device). Errors found before the divide skip it and end the item.
// Configuration may only be written while no item is in flight; writes are
// taken every cycle.
module logical_page_to_device_mapper_core #(
    parameter int MAX_DEVICES = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire lpdm_pkg::t_in  i_in,
    output logic                empty,
    input  wire logic           pop,
    output lpdm_pkg::t_out      o_out,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [30:0]    i_cfg_data
);
    localparam int CW = lpdm_pkg::CNT_W;

    logic [1:0]  r_kind;
    logic [15:0] r_esz;
    logic [30:0] r_total;
    logic [4:0]  r_ndev;
    logic [7:0]  r_resv;

    lpdm_pkg::t_cfg w_cfg;
    logic           w_cmd_valid, w_cmd_pop;
    lpdm_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= lpdm_pkg::KIND_DATA;
            r_esz   <= 16'd1;
            r_total <= '0;
            r_ndev  <= 5'd1;
            r_resv  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lpdm_pkg::CFG_KIND:  r_kind  <= i_cfg_data[1:0];
                lpdm_pkg::CFG_ESZ:   r_esz   <= i_cfg_data[15:0];
                lpdm_pkg::CFG_TOTAL: r_total <= i_cfg_data;
                lpdm_pkg::CFG_NDEV:  r_ndev  <= i_cfg_data[4:0];
                lpdm_pkg::CFG_RESV:  r_resv  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // zero extent size acts as one; device count clamped to 1..MAX_DEVICES
    always_comb begin
        w_cfg.kind  = r_kind;
        w_cfg.esz   = (r_esz == '0) ? 16'd1 : r_esz;
        w_cfg.total = r_total;
        w_cfg.resv  = r_resv;
        if (r_ndev == '0)
            w_cfg.ndev = CW'(1);
        else if (32'(r_ndev) > MAX_DEVICES)
            w_cfg.ndev = CW'(MAX_DEVICES);
        else
            w_cfg.ndev = CW'(r_ndev);
    end

    lpdm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .i_kind      (r_kind),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    lpdm_back #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

// File: src/lpdm_front.sv
// Front end: takes items, classifies them and holds them in a two-entry queue.
// Depends on lpdm_pkg.
`default_nettype none
module lpdm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire lpdm_pkg::t_in  i_in,
    input  wire logic [1:0]     i_kind,
    output logic                o_cmd_valid,
    output lpdm_pkg::t_cmd      o_cmd,
    input  wire logic           i_cmd_pop
);
    lpdm_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    lpdm_pkg::t_cmd w_cmd;
    logic           w_push, w_pop;

    always_comb begin
        w_cmd.page         = i_in.page_number[30:0];
        w_cmd.index        = i_in.entry_index;
        w_cmd.first_extent = i_in.entry_first_extent;
        w_cmd.extent_count = i_in.entry_extent_count;
        if (i_in.action == lpdm_pkg::ACT_WRITE) begin
            w_cmd.op = lpdm_pkg::OP_WRITE;
        end else if (i_kind != lpdm_pkg::KIND_DATA && i_kind != lpdm_pkg::KIND_RAW) begin
            w_cmd.op = lpdm_pkg::OP_BADKIND;
        end else if (i_in.page_number[31]) begin
            w_cmd.op = lpdm_pkg::OP_NEG;
        end else begin
            w_cmd.op = lpdm_pkg::OP_XLATE;
        end
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end
endmodule
`default_nettype wire

// File: src/lpdm_back.sv
// Back end: device tables, range check, serial divider, table search and result register.
// Depends on lpdm_pkg.
`default_nettype none
module lpdm_back #(
    parameter int MAX_DEVICES = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lpdm_pkg::t_cfg i_cfg,
    input  wire logic           i_cmd_valid,
    input  wire lpdm_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    output logic                empty,
    input  wire logic           pop,
    output lpdm_pkg::t_out      o_out
);
    localparam int AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CW = lpdm_pkg::CNT_W;
    localparam int FW = lpdm_pkg::FIRST_W;
    localparam logic signed [FW-1:0] EXT_HI = FW'(64'sh8000_0000);
    localparam logic signed [FW-1:0] EXT_LO = -EXT_HI;

    logic [30:0] r_fe_mem  [MAX_DEVICES];
    logic [30:0] r_cnt_mem [MAX_DEVICES];
    logic [30:0] r_fe_q, r_cnt_q;

    lpdm_pkg::t_state r_state, n_state;
    logic [30:0]          r_page, n_page;
    logic [30:0]          r_dvd, n_dvd;    // dividend shifting out, quotient shifting in
    logic [15:0]          r_rem, n_rem;
    logic [4:0]           r_step, n_step;
    logic signed [CW:0]   r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0]        r_mid, n_mid, r_idx, n_idx;
    logic signed [FW-1:0] r_first, n_first;
    logic signed [32:0]   r_ma, n_ma;
    logic signed [49:0]   r_prod, n_prod;
    lpdm_pkg::t_out       r_res, n_res, r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic [AW-1:0]        w_rd_addr;
    logic                 w_we;
    logic [CW+1:0]        w_sum;
    logic [CW-1:0]        w_mid;
    logic [16:0]          w_sh;
    logic [16:0]          w_sub;
    logic [16:0]          w_resn;
    logic signed [32:0]   w_base, w_len;
    logic signed [FW-1:0] w_acc, w_ext;
    logic signed [50:0]   w_off;

    assign w_sum = {2'b0, r_lo[CW-1:0]} + {2'b0, r_hi[CW-1:0]};
    assign w_mid = w_sum[CW:1];
    assign w_rd_addr = (r_state == lpdm_pkg::S_BS_RD) ? w_mid[AW-1:0] : r_idx[AW-1:0];
    assign w_we = (r_state == lpdm_pkg::S_IDLE) && i_cmd_valid
               && (i_cmd.op == lpdm_pkg::OP_WRITE) && (32'(i_cmd.index) < MAX_DEVICES);

    assign w_sh   = {r_rem, r_dvd[30]};
    assign w_sub  = w_sh - {1'b0, i_cfg.esz};
    assign w_resn = 17'(i_cfg.resv * i_cfg.ndev);
    assign w_base = $signed({2'b0, i_cfg.total}) - $signed({16'b0, w_resn});
    assign w_len  = $signed({2'b0, r_cnt_q}) - $signed({25'b0, i_cfg.resv});
    assign w_acc  = r_first + FW'(w_len);
    assign w_ext  = r_first - $signed({(FW-8)'(0), i_cfg.resv});
    assign w_off  = $signed({20'b0, r_page}) - 51'(r_prod);

    assign o_cmd_pop = (r_state == lpdm_pkg::S_IDLE) && i_cmd_valid;
    assign empty     = !r_out_valid;
    assign o_out     = r_out;

    always_comb begin
        n_state     = r_state;
        n_page      = r_page;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_step      = r_step;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_first     = r_first;
        n_ma        = r_ma;
        n_prod      = r_prod;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !pop;
        case (r_state)
            lpdm_pkg::S_IDLE: begin
                n_res = '0;
                if (i_cmd_valid) begin
                    n_page = i_cmd.page;
                    case (i_cmd.op)
                        lpdm_pkg::OP_WRITE: n_state = lpdm_pkg::S_IDLE;
                        lpdm_pkg::OP_BADKIND: begin
                            n_res.status = lpdm_pkg::ST_BADKIND;
                            n_state      = lpdm_pkg::S_DONE;
                        end
                        lpdm_pkg::OP_NEG: begin
                            n_res.status = lpdm_pkg::ST_RANGE;
                            n_state      = lpdm_pkg::S_DONE;
                        end
                        default: begin
                            n_ma    = (i_cfg.kind == lpdm_pkg::KIND_DATA)
                                    ? $signed({2'b0, i_cfg.total}) : w_base;
                            n_state = lpdm_pkg::S_LIM_MUL;
                        end
                    endcase
                end
            end
            lpdm_pkg::S_LIM_MUL: begin
                n_prod  = r_ma * $signed({1'b0, i_cfg.esz});
                n_state = lpdm_pkg::S_LIM_CHK;
            end
            lpdm_pkg::S_LIM_CHK: begin
                if ($signed({19'b0, r_page}) >= r_prod) begin
                    n_res.status = lpdm_pkg::ST_RANGE;
                    n_state      = lpdm_pkg::S_DONE;
                end else begin
                    n_dvd   = r_page;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = lpdm_pkg::S_DIV;
                end
            end
            lpdm_pkg::S_DIV: begin
                if (!w_sub[16]) begin
                    n_rem = w_sub[15:0];
                    n_dvd = {r_dvd[29:0], 1'b1};
                end else begin
                    n_rem = w_sh[15:0];
                    n_dvd = {r_dvd[29:0], 1'b0};
                end
                n_step = r_step + 5'd1;
                if (r_step == 5'd30) begin
                    n_lo    = '0;
                    n_hi    = $signed({1'b0, i_cfg.ndev}) - (CW+1)'(1);
                    n_idx   = '0;
                    n_first = '0;
                    n_state = (i_cfg.kind == lpdm_pkg::KIND_DATA)
                            ? lpdm_pkg::S_BS_RD : lpdm_pkg::S_RS_RD;
                end
            end
            lpdm_pkg::S_BS_RD: begin
                if (r_lo <= r_hi) begin
                    n_mid   = w_mid;
                    n_state = lpdm_pkg::S_BS_CMP;
                end else if (r_hi[CW]) begin
                    n_res.status = lpdm_pkg::ST_RANGE;
                    n_state      = lpdm_pkg::S_DONE;
                end else begin
                    n_idx   = r_hi[CW-1:0];
                    n_state = lpdm_pkg::S_OFF_RD;
                end
            end
            lpdm_pkg::S_BS_CMP: begin
                if (r_fe_q == r_dvd) begin
                    n_idx   = r_mid;
                    n_ma    = $signed({2'b0, r_fe_q});
                    n_state = lpdm_pkg::S_OFF_MUL;
                end else begin
                    if (r_fe_q > r_dvd) n_hi = $signed({1'b0, r_mid}) - (CW+1)'(1);
                    else                n_lo = $signed({1'b0, r_mid}) + (CW+1)'(1);
                    n_state = lpdm_pkg::S_BS_RD;
                end
            end
            lpdm_pkg::S_RS_RD: begin
                if (r_idx >= i_cfg.ndev) begin
                    n_res.status = lpdm_pkg::ST_RANGE;
                    n_state      = lpdm_pkg::S_DONE;
                end else begin
                    n_state = lpdm_pkg::S_RS_CMP;
                end
            end
            lpdm_pkg::S_RS_CMP: begin
                if ($signed({(FW-31)'(0), r_dvd}) < w_acc) begin
                    // offset saturates either way beyond +/-2^31 extents
                    if (w_ext > EXT_HI)      n_ma = 33'(EXT_HI);
                    else if (w_ext < EXT_LO) n_ma = 33'(EXT_LO);
                    else                     n_ma = 33'(w_ext);
                    n_state = lpdm_pkg::S_OFF_MUL;
                end else begin
                    n_first = w_acc;
                    n_idx   = r_idx + CW'(1);
                    n_state = lpdm_pkg::S_RS_RD;
                end
            end
            lpdm_pkg::S_OFF_RD: n_state = lpdm_pkg::S_OFF_LD;
            lpdm_pkg::S_OFF_LD: begin
                n_ma    = $signed({2'b0, r_fe_q});
                n_state = lpdm_pkg::S_OFF_MUL;
            end
            lpdm_pkg::S_OFF_MUL: begin
                n_prod  = r_ma * $signed({1'b0, i_cfg.esz});
                n_state = lpdm_pkg::S_OFF_SUB;
            end
            lpdm_pkg::S_OFF_SUB: begin
                n_res.status        = lpdm_pkg::ST_OK;
                n_res.device_number = r_idx[3:0];
                if (w_off < 0)
                    n_res.offset_in_device = '0;
                else if (w_off > 51'sh7FFF_FFFF)
                    n_res.offset_in_device = '1;
                else
                    n_res.offset_in_device = w_off[30:0];
                n_state = lpdm_pkg::S_DONE;
            end
            lpdm_pkg::S_DONE: begin
                if (!r_out_valid || pop) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = lpdm_pkg::S_IDLE;
                end
            end
            default: n_state = lpdm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpdm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page  <= n_page;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_step  <= n_step;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_idx   <= n_idx;
        r_first <= n_first;
        r_ma    <= n_ma;
        r_prod  <= n_prod;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_fe_mem[AW'(i_cmd.index)]  <= i_cmd.first_extent;
            r_cnt_mem[AW'(i_cmd.index)] <= i_cmd.extent_count;
        end
        r_fe_q  <= r_fe_mem[w_rd_addr];
        r_cnt_q <= r_cnt_mem[w_rd_addr];
    end
endmodule
`default_nettype wire
